@@ hw/rtl/ksg_pkg.sv @@
package ksg_pkg;

  // op codes carried on the input tuser
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  // sqrt(3)/2 with 32 fraction bits
  localparam logic [63:0] SQ3H_Q32 = 64'd3719550787;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;    // load root frame from the input word
    logic inc;      // advance child index at the current level
    logic rd;       // read frame at the current level
    logic ld;       // load divider and child select
    logic step;     // one divider chunk
    logic fin;      // capture third points
    logic diff;     // form point differences
    logic mul;      // sin60 products
    logic off;      // rotation offsets
    logic wr;       // write child frame one level down
    logic wr_leaf;  // child frame is the leaf
    logic emit;     // load output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic child3;   // child index at the current level is the last one
    logic last;     // every level sits on its last child
  } status_t;

  // sin(60 deg) rounded to frac fraction bits
  function automatic logic [31:0] sin60_fixed(input int unsigned frac);
    logic [63:0] acc;
    acc = SQ3H_Q32 + (64'd1 << (31 - frac));
    return 32'(acc >> (32 - frac));
  endfunction

endpackage

@@ hw/rtl/koch_segment_generator_unit.sv @@
// Koch curve segment generator. A start word (tuser 0) loads a segment and
// returns the first leaf segment of its Koch subdivision at the depth held in
// the configuration register (1 to MAX_DEPTH, depth 1 returns the segment
// itself); each next word (tuser 1) returns the following leaf in depth-first
// order, with tlast on the final one, and a next word with no traversal
// running returns nothing. Words are handled one at a time. Each level of
// descent passes through the chunked divide-by-three unit, which takes eight
// dividend bits per cycle, and the multiply and rounding stages behind it.
// A next word climbs the levels until a branch with siblings left is found.
// A finished leaf waits in the output register, and a new word is taken
// while it waits.
module koch_segment_generator_unit #(
  parameter int MAX_DEPTH  = 8,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8,
  localparam int DataW     = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x, start_y, end_x, end_y, zero padding
  input  logic [DataW-1:0] s_axis_tdata,
  // op
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // from_x, from_y, to_x, to_y, zero padding
  output logic [DataW-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int FrameW = 4 * COORD_BITS;
  localparam int LvlW   = $clog2(MAX_DEPTH);
  localparam int LevW   = $clog2(MAX_DEPTH + 1);
  localparam int NumW   = COORD_BITS + 2;
  localparam int Chunks = (NumW + 7) / 8;

  ksg_pkg::cmd_t    cmd;
  ksg_pkg::status_t status;
  logic [LvlW-1:0]  lvl;
  logic [LevW-1:0]  levels;
  logic [FrameW-1:0] out_frame;

  ksg_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .Chunks    (Chunks),
    .LvlW      (LvlW),
    .LevW      (LevW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_op_i      (s_axis_tuser[0]),
    .s_ready_o   (s_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd),
    .lvl_o       (lvl),
    .levels_o    (levels)
  );

  ksg_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .NumW       (NumW),
    .Chunks     (Chunks),
    .LvlW       (LvlW),
    .LevW       (LevW)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .lvl_i       (lvl),
    .levels_i    (levels),
    .in_frame_i  (s_axis_tdata[FrameW-1:0]),
    .status_o    (status),
    .out_frame_o (out_frame),
    .out_last_o  (m_axis_tlast)
  );

  // output word, padded with zeros to whole bytes
  assign m_axis_tdata = DataW'(out_frame);

endmodule

@@ hw/rtl/ksg_div3.sv @@
module ksg_div3 #(
  parameter int NumW   = 26,
  parameter int Chunks = 4
) (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  logic                 step_i,
  input  logic [3:0][NumW-1:0] num_i,
  output logic [3:0][NumW-1:0] quot_o
);

  localparam int PadW = Chunks * 8;
  localparam int Shift = 11;
  // ceil(2^11 / 3): exact floor(v / 3) for v below 2048
  localparam logic [9:0] Recip = 10'd683;

  logic [PadW-1:0] mag_q [4];
  logic [PadW-1:0] quo_q [4];
  logic [1:0]      rem_q [4];
  logic            neg_q [4];

  logic [NumW-1:0] abs_in [4];
  logic [9:0]      v_w    [4];
  logic [19:0]     prod_w [4];
  logic [7:0]      q8_w   [4];
  logic [9:0]      r10_w  [4];
  logic [NumW-1:0] qmag_w [4];

  // one byte of the dividend per lane and cycle, remainder carried on
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      abs_in[l] = num_i[l][NumW-1] ? (~num_i[l] + NumW'(1)) : num_i[l];
      v_w[l]    = {rem_q[l], mag_q[l][PadW-1 -: 8]};
      prod_w[l] = {10'd0, v_w[l]} * {10'd0, Recip};
      q8_w[l]   = prod_w[l][Shift+7:Shift];
      r10_w[l]  = v_w[l] - ({1'b0, q8_w[l], 1'b0} + {2'b00, q8_w[l]});
      qmag_w[l] = quo_q[l][NumW-1:0];
      quot_o[l] = neg_q[l] ? (~qmag_w[l] + NumW'(1)) : qmag_w[l];
    end
  end

  // lane registers, truncation toward zero by sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      if (load_i) begin
        neg_q[l] <= num_i[l][NumW-1];
        mag_q[l] <= PadW'(abs_in[l]);
        rem_q[l] <= 2'b00;
        quo_q[l] <= '0;
      end else if (step_i) begin
        mag_q[l] <= {mag_q[l][PadW-9:0], 8'h00};
        quo_q[l] <= {quo_q[l][PadW-9:0], q8_w[l]};
        rem_q[l] <= r10_w[l][1:0];
      end
    end
  end

endmodule

@@ hw/rtl/ksg_ctrl.sv @@
module ksg_ctrl #(
  parameter int MAX_DEPTH = 8,
  parameter int Chunks    = 4,
  parameter int LvlW      = 3,
  parameter int LevW      = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             s_valid_i,
  input  logic             s_op_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  ksg_pkg::status_t status_i,
  output ksg_pkg::cmd_t    cmd_o,
  output logic [LvlW-1:0]  lvl_o,
  output logic [LevW-1:0]  levels_o
);

  localparam int CntW = $clog2(Chunks);

  typedef enum logic [3:0] {
    StIdle, StSrch, StRd, StLd, StDiv, StFin, StDiff, StMul, StOff, StWr, StEmit
  } state_e;

  state_e            state_q;
  logic [LvlW-1:0]   k_q;
  logic [LevW-1:0]   levels_q;
  logic              active_q;
  logic [CntW-1:0]   cnt_q;
  logic              m_valid_q;
  logic [3:0]        depth_q;

  logic              s_fire;
  logic              is_start;
  logic              out_free;
  logic              next_is_leaf;
  logic [4:0]        d5;
  logic [LevW-1:0]   clamp_lv;

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = m_valid_q;
  assign lvl_o     = k_q;
  assign levels_o  = levels_q;
  assign s_fire    = s_valid_i && s_ready_o;
  assign is_start  = (s_op_i == ksg_pkg::OP_START);
  assign out_free  = !m_valid_q || m_ready_i;
  assign next_is_leaf = (LevW'(k_q) + LevW'(1)) == (levels_q - LevW'(1));

  // depth clamped to one .. MAX_DEPTH
  always_comb begin
    d5 = {1'b0, depth_q};
    if (d5 == 5'd0) begin
      clamp_lv = LevW'(1);
    end else if (d5 > 5'(MAX_DEPTH)) begin
      clamp_lv = LevW'(MAX_DEPTH);
    end else begin
      clamp_lv = LevW'(d5);
    end
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: cmd_o.start = s_fire && is_start;
      StSrch: cmd_o.inc   = !status_i.child3;
      StRd:   cmd_o.rd    = 1'b1;
      StLd:   cmd_o.ld    = 1'b1;
      StDiv:  cmd_o.step  = 1'b1;
      StFin:  cmd_o.fin   = 1'b1;
      StDiff: cmd_o.diff  = 1'b1;
      StMul:  cmd_o.mul   = 1'b1;
      StOff:  cmd_o.off   = 1'b1;
      StWr: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wr_leaf = next_is_leaf;
      end
      StEmit: cmd_o.emit = out_free;
      default: cmd_o = '0;
    endcase
  end

  // sequencer: descend one level per pass, search upwards for the next branch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      k_q       <= '0;
      levels_q  <= LevW'(1);
      active_q  <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      depth_q   <= 4'd4;
    end else begin
      if (cfg_we_i) begin
        depth_q <= cfg_wdata_i;
      end
      // output valid: set on emit, cleared once the word is taken
      if ((state_q == StEmit) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_fire) begin
            if (is_start) begin
              levels_q <= clamp_lv;
              active_q <= 1'b1;
              k_q      <= '0;
              state_q  <= (clamp_lv == LevW'(1)) ? StEmit : StRd;
            end else if (active_q) begin
              if (levels_q == LevW'(1)) begin
                active_q <= 1'b0;
              end else begin
                k_q     <= LvlW'(levels_q - LevW'(2));
                state_q <= StSrch;
              end
            end
          end
        end
        StSrch: begin
          if (!status_i.child3) begin
            state_q <= StRd;
          end else if (k_q == '0) begin
            active_q <= 1'b0;
            state_q  <= StIdle;
          end else begin
            k_q <= k_q - LvlW'(1);
          end
        end
        StRd: state_q <= StLd;
        StLd: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (cnt_q == CntW'(Chunks - 1)) begin
            state_q <= StFin;
          end else begin
            cnt_q <= cnt_q + CntW'(1);
          end
        end
        StFin:  state_q <= StDiff;
        StDiff: state_q <= StMul;
        StMul:  state_q <= StOff;
        StOff:  state_q <= StWr;
        StWr: begin
          if (next_is_leaf) begin
            state_q <= StEmit;
          end else begin
            k_q     <= k_q + LvlW'(1);
            state_q <= StRd;
          end
        end
        StEmit: begin
          if (out_free) begin
            if (status_i.last) begin
              active_q <= 1'b0;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> active_q)
    else $error("leaf emitted with no traversal running");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (LevW'(k_q) < levels_q))
    else $error("level index beyond latched depth");

  a_levels_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (levels_q != '0) && (levels_q <= LevW'(MAX_DEPTH)))
    else $error("latched depth out of range");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.last) |=> !active_q)
    else $error("traversal still active after final leaf");
`endif

endmodule

@@ hw/rtl/ksg_dp.sv @@
module ksg_dp #(
  parameter int MAX_DEPTH  = 8,
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8,
  parameter int NumW       = 26,
  parameter int Chunks     = 4,
  parameter int LvlW       = 3,
  parameter int LevW       = 4
) (
  input  logic                    clk_i,
  input  ksg_pkg::cmd_t           cmd_i,
  input  logic [LvlW-1:0]         lvl_i,
  input  logic [LevW-1:0]         levels_i,
  input  logic [4*COORD_BITS-1:0] in_frame_i,
  output ksg_pkg::status_t        status_o,
  output logic [4*COORD_BITS-1:0] out_frame_o,
  output logic                    out_last_o
);

  localparam int CW     = COORD_BITS;
  localparam int FrameW = 4 * CW;
  localparam int SinW   = FRAC_BITS + 2;
  localparam int ProdW  = CW + 1 + SinW;
  localparam int AccW   = CW + FRAC_BITS + 5;
  localparam logic signed [SinW-1:0] Sin60 = SinW'(ksg_pkg::sin60_fixed(FRAC_BITS));

  localparam logic [1:0] ChildHead = 2'd0;
  localparam logic [1:0] ChildRise = 2'd1;
  localparam logic [1:0] ChildFall = 2'd2;
  localparam logic [1:0] ChildTail = 2'd3;

  // frame store: {to_y, to_x, from_y, from_x} per level
  logic [FrameW-1:0] mem_q [MAX_DEPTH];
  logic [FrameW-1:0] rd_q;
  logic [1:0]        child_q [MAX_DEPTH];
  logic [1:0]        sel_q;

  logic signed [CW-1:0]    x3_q, y3_q, x4_q, y4_q;
  logic signed [CW:0]      dx_q, dy_q;
  logic signed [ProdW-1:0] px_q, py_q;
  logic [CW-1:0]           offx_q, offy_q;
  logic [FrameW-1:0]       leaf_q;
  logic [FrameW-1:0]       out_q;
  logic                    last_q;

  logic signed [CW-1:0]  x1_w, y1_w, x2_w, y2_w;
  logic [3:0][NumW-1:0]  num_w;
  logic [3:0][NumW-1:0]  quot_w;
  logic [LvlW-1:0]       lvl_nxt;
  logic signed [AccW-1:0] accx_w, accy_w;
  logic [CW-1:0]         x5_w, y5_w;
  logic [FrameW-1:0]     child_word;
  logic                  last_w;

  assign x1_w = rd_q[CW-1:0];
  assign y1_w = rd_q[2*CW-1:CW];
  assign x2_w = rd_q[3*CW-1:2*CW];
  assign y2_w = rd_q[4*CW-1:3*CW];
  assign lvl_nxt = lvl_i + LvlW'(1);

  // third point numerators: 2*p1+p2 and p1+2*p2
  assign num_w[0] = (NumW'(x1_w) <<< 1) + NumW'(x2_w);
  assign num_w[1] = (NumW'(y1_w) <<< 1) + NumW'(y2_w);
  assign num_w[2] = NumW'(x1_w) + (NumW'(x2_w) <<< 1);
  assign num_w[3] = NumW'(y1_w) + (NumW'(y2_w) <<< 1);

  ksg_div3 #(
    .NumW   (NumW),
    .Chunks (Chunks)
  ) u_div3 (
    .clk_i  (clk_i),
    .load_i (cmd_i.ld),
    .step_i (cmd_i.step),
    .num_i  (num_w),
    .quot_o (quot_w)
  );

  // rotation offsets, rounded to nearest with ties upward
  assign accx_w = (AccW'(dx_q) <<< FRAC_BITS) + (AccW'(px_q) <<< 1)
                + (AccW'(1) <<< FRAC_BITS);
  assign accy_w = (AccW'(dy_q) <<< FRAC_BITS) - (AccW'(py_q) <<< 1)
                + (AccW'(1) <<< FRAC_BITS);

  // bump point and child selection
  always_comb begin
    x5_w = x3_q + offx_q;
    y5_w = y3_q + offy_q;
    case (sel_q)
      ChildHead: child_word = {y3_q, x3_q, y1_w, x1_w};
      ChildRise: child_word = {y5_w, x5_w, y3_q, x3_q};
      ChildFall: child_word = {y4_q, x4_q, y5_w, x5_w};
      ChildTail: child_word = {y2_w, x2_w, y4_q, x4_q};
      default:   child_word = {y2_w, x2_w, y4_q, x4_q};
    endcase
  end

  // final leaf when every level above it sits on its last child
  always_comb begin
    last_w = 1'b1;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((i + 1) < int'(levels_i) && child_q[i] != ChildTail) begin
        last_w = 1'b0;
      end
    end
  end

  assign status_o.child3 = (child_q[lvl_i] == ChildTail);
  assign status_o.last   = last_w;
  assign out_frame_o     = out_q;
  assign out_last_o      = last_q;

  // frame store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mem_q[LvlW'(0)] <= in_frame_i;
    end else if (cmd_i.wr) begin
      mem_q[lvl_nxt] <= child_word;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[lvl_i];
    end
  end

  // child indexes per level
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      child_q[LvlW'(0)] <= ChildHead;
    end
    if (cmd_i.inc) begin
      child_q[lvl_i] <= child_q[lvl_i] + 2'd1;
    end
    if (cmd_i.wr) begin
      child_q[lvl_nxt] <= ChildHead;
    end
  end

  // split pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      sel_q <= child_q[lvl_i];
    end
    if (cmd_i.fin) begin
      x3_q <= quot_w[0][CW-1:0];
      y3_q <= quot_w[1][CW-1:0];
      x4_q <= quot_w[2][CW-1:0];
      y4_q <= quot_w[3][CW-1:0];
    end
    if (cmd_i.diff) begin
      dx_q <= (CW+1)'(x4_q) - (CW+1)'(x3_q);
      dy_q <= (CW+1)'(y4_q) - (CW+1)'(y3_q);
    end
    if (cmd_i.mul) begin
      px_q <= dy_q * Sin60;
      py_q <= dx_q * Sin60;
    end
    if (cmd_i.off) begin
      offx_q <= accx_w[FRAC_BITS+1 +: CW];
      offy_q <= accy_w[FRAC_BITS+1 +: CW];
    end
  end

  // leaf and output words
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      leaf_q <= in_frame_i;
    end else if (cmd_i.wr && cmd_i.wr_leaf) begin
      leaf_q <= child_word;
    end
    if (cmd_i.emit) begin
      out_q  <= leaf_q;
      last_q <= last_w;
    end
  end

endmodule
